@@ rtl/signature_class_dedup_assert.svh @@
// ----------------------------------------------------------------------------
// signature_class_dedup_assert.svh
// Assertion macros used by the signature class dedup datapath (scd_dp).
// ----------------------------------------------------------------------------
`ifndef SIGNATURE_CLASS_DEDUP_ASSERT_SVH
`define SIGNATURE_CLASS_DEDUP_ASSERT_SVH

// condition holds at every edge out of reset
`define SCD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define SCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg
// Types and constants for the signature class dedup table.
// ----------------------------------------------------------------------------
package scd_pkg;

  localparam int MAX_CLASSES   = 64;
  localparam int MAX_SIG_TRITS = 16;
  localparam int SIG_W         = 32;
  localparam int CONF_W        = 16;
  localparam int CAND_W        = 10;
  localparam int CLS_W         = 6;
  localparam int CNT_W         = 7;
  localparam int TRIT_CFG_W    = 5;
  localparam int CFG_DATA_W    = 5;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CAND_W-1:0]     CAND_MAX    = CAND_W'(1023);
  localparam logic [CNT_W-1:0]      CLASS_LIMIT = CNT_W'(MAX_CLASSES);
  localparam logic [TRIT_CFG_W-1:0] TRITS_LIMIT = TRIT_CFG_W'(MAX_SIG_TRITS);

  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_CONF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRITS_IN_USE = 1'b1;

  typedef struct packed {
    logic [SIG_W-1:0]  trit_signature;
    logic [CONF_W-1:0] confidence_bits;
    logic              last_of_build;
  } scd_in_t;

  typedef struct packed {
    logic [CLS_W-1:0]  class_index;
    logic              new_class;
    logic [CAND_W-1:0] representative;
    logic [CAND_W-1:0] candidate_number;
    logic [CNT_W-1:0]  class_count;
    logic              table_full;
  } scd_out_t;

  typedef struct packed {
    logic [SIG_W-1:0]  sig;
    logic [CONF_W-1:0] conf;
    logic [CAND_W-1:0] rep;
  } scd_entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } scd_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic out_busy;
  } scd_sts_t;

endpackage

@@ rtl/scd_ctrl.sv @@
// ----------------------------------------------------------------------------
// scd_ctrl
// Sequencer: accept a request, run the class search, commit the result.
// ----------------------------------------------------------------------------
module scd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scd_pkg::scd_sts_t sts,
  output scd_pkg::scd_cmd_t cmd
);
  import scd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts.hit || sts.scan_done) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/scd_dp.sv @@
// ----------------------------------------------------------------------------
// scd_dp
// Datapath: config, request latch, class key memory, scan and result register.
// ----------------------------------------------------------------------------
module scd_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  scd_pkg::scd_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output scd_pkg::scd_out_t                  out_data,
  input  scd_pkg::scd_cmd_t                  cmd,
  output scd_pkg::scd_sts_t                  sts
);
  import scd_pkg::*;

  logic                  cmp_conf_r;
  logic [TRIT_CFG_W-1:0] trits_r;

  scd_in_t               req_r;
  logic [SIG_W-1:0]      sig_mask_r;
  logic [CONF_W-1:0]     conf_mask_r;
  logic [TRIT_CFG_W-1:0] n_trits;

  scd_entry_t            mem [MAX_CLASSES];
  scd_entry_t            rd_data_r;
  logic [CNT_W-1:0]      scan_idx_r;
  logic                  pend_r;
  logic [CLS_W-1:0]      pend_idx_r;
  logic                  issue;
  logic                  match;

  logic [CNT_W-1:0]      class_cnt_r, class_cnt_nxt;
  logic [CAND_W-1:0]     cand_cnt_r, cand_cnt_nxt;
  logic                  room;
  logic                  mem_we;

  logic                  out_valid_r;
  scd_out_t              out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_conf_r <= 1'b0;
      trits_r    <= TRITS_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COMPARE_CONF: cmp_conf_r <= cfg_data[0];
        REG_TRITS_IN_USE: trits_r    <= cfg_data[TRIT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_trits = (trits_r > TRITS_LIMIT) ? TRITS_LIMIT : trits_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= in_data;
      sig_mask_r  <= ~({SIG_W{1'b1}} << {1'b0, n_trits, 1'b0});
      conf_mask_r <= ~({CONF_W{1'b1}} << n_trits);
    end
  end

  // one key read issued per cycle while the scan runs and keys remain, compared the cycle after
  assign issue = cmd.scan && (scan_idx_r < class_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
    end else if (cmd.load) begin
      scan_idx_r <= '0;
      pend_r     <= 1'b0;
    end else if (cmd.scan) begin
      pend_r <= issue;
      if (issue) begin
        scan_idx_r <= scan_idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r <= scan_idx_r[CLS_W-1:0];
      rd_data_r  <= mem[scan_idx_r[CLS_W-1:0]];
    end
  end

  assign room   = class_cnt_r < CLASS_LIMIT;
  assign mem_we = cmd.commit && !sts.hit && room;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[class_cnt_r[CLS_W-1:0]] <= '{sig:  req_r.trit_signature,
                                       conf: req_r.confidence_bits,
                                       rep:  cand_cnt_r};
    end
  end

  assign match = (((rd_data_r.sig ^ req_r.trit_signature) & sig_mask_r) == '0) &&
                 (!cmp_conf_r ||
                  (((rd_data_r.conf ^ req_r.confidence_bits) & conf_mask_r) == '0));

  assign sts.hit       = pend_r && match;
  assign sts.scan_done = !pend_r && (scan_idx_r == class_cnt_r);
  assign sts.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    out_data_nxt                  = '0;
    out_data_nxt.candidate_number = cand_cnt_r;
    class_cnt_nxt                 = class_cnt_r;
    priority if (sts.hit) begin
      out_data_nxt.class_index    = pend_idx_r;
      out_data_nxt.representative = rd_data_r.rep;
    end else if (room) begin
      out_data_nxt.class_index    = class_cnt_r[CLS_W-1:0];
      out_data_nxt.new_class      = 1'b1;
      out_data_nxt.representative = cand_cnt_r;
      class_cnt_nxt               = class_cnt_r + CNT_W'(1);
    end else begin
      out_data_nxt.table_full     = 1'b1;
    end
    out_data_nxt.class_count = class_cnt_nxt;
    cand_cnt_nxt = (cand_cnt_r == CAND_MAX) ? cand_cnt_r : cand_cnt_r + CAND_W'(1);
    if (req_r.last_of_build) begin
      class_cnt_nxt = '0;
      cand_cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_cnt_r <= '0;
      cand_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        class_cnt_r <= class_cnt_nxt;
        cand_cnt_r  <= cand_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "signature_class_dedup_assert.svh"

  `SCD_ASSERT_ALWAYS(a_count_bound, class_cnt_r <= CLASS_LIMIT, "class count above limit")
  `SCD_ASSERT_NEXT(a_full_flag, cmd.commit && !sts.hit && !room, out_data_r.table_full && !out_data_r.new_class, "full table miss not flagged")
  `SCD_ASSERT_NEXT(a_hit_result, cmd.commit && sts.hit, !out_data_r.new_class && (out_data_r.class_index == $past(pend_idx_r)), "hit result mismatch")
  `SCD_ASSERT_NEXT(a_insert_count, mem_we && !req_r.last_of_build, class_cnt_r == $past(class_cnt_r) + CNT_W'(1), "insert did not bump class count")

endmodule

@@ rtl/signature_class_dedup.sv @@
// ----------------------------------------------------------------------------
// signature_class_dedup
// First-fit class table: maps each signature to a class; flags misses when full.
//
//   port group | dir | handshake          | payload
//   in_        | in  | in_valid/in_ready  | scd_in_t  (signature, confidence, last)
//   out_       | out | out_valid/out_ready| scd_out_t (class, rep, counts, flags)
//   cfg_       | in  | cfg_we             | cfg_index, cfg_data
//
// One request at a time; a new request is accepted only once the linear key
// scan, one memory read per cycle until a hit or the last stored class, and the
// commit are done.
// The result register frees the input side while a result waits; commit of
// the next result waits for out_ready. Reset is synchronous, active low, and
// clears counters and config; the key memory needs no clearing.
// ----------------------------------------------------------------------------
module signature_class_dedup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  scd_pkg::scd_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output scd_pkg::scd_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [scd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scd_pkg::*;

  scd_cmd_t cmd;
  scd_sts_t sts;

  scd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  scd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
